### rtl/wlh_pkg.sv
// Package for the word length histogram block.
// Holds item types, opcode and command codes, and default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wlh_pkg;

   // Default sizes for the top-level parameters.
   localparam int BINS_DEFAULT       = 1024;
   localparam int COUNT_BITS_DEFAULT = 32;

   // Fixed widths of the item fields.
   localparam int OPCODE_W      = 2;
   localparam int CHAR_W        = 8;
   localparam int INDEX_W       = 10;
   localparam int COUNT_OUT_W   = 32;
   localparam int LENGTH_OUT_W  = 10;

   // Widest word length carried in a command (BINS is at most 65536).
   localparam int LEN_FIELD_W = 16;

   // Depths of the queues between the parts.
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Input opcodes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_BYTE  = 2'd0,
      OP_EOS   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // What the back part does after an optional word close.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_EOS   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // One input item.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [CHAR_W-1:0]   char_byte;
      logic [INDEX_W-1:0]  bin_index;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [COUNT_OUT_W-1:0]  bin_count;
      logic [COUNT_OUT_W-1:0]  word_count;
      logic [COUNT_OUT_W-1:0]  max_count;
      logic [LENGTH_OUT_W-1:0] max_length;
      logic                    overflow_seen;
   } rsp_type;

   // Command from the front part to the back part.
   typedef struct packed {
      kind_type               kind;
      logic                   close_word;
      logic                   close_long;
      logic [LEN_FIELD_W-1:0] close_len;
      logic [INDEX_W-1:0]     bin_index;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/wlh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the histogram store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wlh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/wlh_fifo.sv
// Small register queue used between the front and back parts and on the result side.
// No dependencies; DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module wlh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### rtl/wlh_front.sv
// Front part: accepts input items, tracks the pending word and emits commands.
// Depends on wlh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wlh_front #(
   parameter int BINS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire wlh_pkg::req_type req,
   output logic                  cmd_push,
   output wlh_pkg::cmd_type      cmd
);

   import wlh_pkg::*;

   localparam int RW = $clog2(BINS + 1);

   logic [RW-1:0] run_ff, run_in;
   logic          word_char;
   logic          pending;

   // A word character is an ASCII digit or letter.
   function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
      is_word_char = (c >= 8'h30 && c <= 8'h39) ||
                     (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A);
   endfunction

   assign word_char = is_word_char(req.char_byte);
   assign pending   = (run_ff != '0);

   // Classify the item and build the command for the back part.
   always_comb begin
      run_in         = run_ff;
      cmd_push       = 1'b0;
      cmd.kind       = KIND_NONE;
      cmd.close_word = pending;
      cmd.close_long = (run_ff >= RW'(BINS));
      cmd.close_len  = LEN_FIELD_W'(run_ff);
      cmd.bin_index  = req.bin_index;
      if (accept) begin
         case (req.opcode)
            OP_BYTE: begin
               if (word_char) begin
                  if (run_ff < RW'(BINS)) begin
                     run_in = run_ff + RW'(1);
                  end
               end else if (pending) begin
                  cmd_push = 1'b1;
                  run_in   = '0;
               end
            end
            OP_EOS: begin
               cmd_push = 1'b1;
               cmd.kind = KIND_EOS;
               run_in   = '0;
            end
            OP_READ: begin
               cmd_push       = 1'b1;
               cmd.kind       = KIND_READ;
               cmd.close_word = 1'b0;
            end
            OP_CLEAR: begin
               cmd_push       = 1'b1;
               cmd.kind       = KIND_CLEAR;
               cmd.close_word = 1'b0;
               run_in         = '0;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

endmodule

`default_nettype wire

### rtl/wlh_back.sv
// Back part: updates the histogram store and totals, and builds result items.
// Depends on wlh_pkg and wlh_ram.
`timescale 1ns / 1ps
`default_nettype none

module wlh_back #(
   parameter int BINS       = 1024,
   parameter int COUNT_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_empty,
   input  wire wlh_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output wlh_pkg::rsp_type      rsp,
   output logic                  clearing
);

   import wlh_pkg::*;

   localparam int LB = $clog2(BINS);
   localparam int CB = COUNT_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_DATA   = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [LB-1:0] clr_addr_ff, clr_addr_in;
   logic [CB-1:0] bin_ff, bin_in;
   logic [CB-1:0] words_ff, words_in;
   logic [CB-1:0] largest_ff, largest_in;
   logic [LB-1:0] longest_ff, longest_in;
   logic          ovf_ff, ovf_in;

   logic          wr_en;
   logic [LB-1:0] wr_addr;
   logic [CB-1:0] wr_data;
   logic [LB-1:0] rd_addr;
   logic [CB-1:0] rd_data;
   logic [CB-1:0] bumped;
   logic [LB-1:0] len;
   logic          in_range;

   wlh_ram #(
      .WIDTH (CB),
      .DEPTH (BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The read address follows the queue head so data is ready in the next state.
   assign rd_addr  = cmd.close_word ? LB'(cmd.close_len) : LB'(cmd.bin_index);
   assign len      = LB'(cmd_ff.close_len);
   assign bumped   = (rd_data == '1) ? rd_data : rd_data + CB'(1);
   assign in_range = (32'(cmd_ff.bin_index) < 32'(BINS));
   assign clearing = (state_ff == ST_CLEAR);

   // Result item from the registered totals.
   always_comb begin
      rsp.bin_count     = (cmd_ff.kind == KIND_READ) ? COUNT_OUT_W'(bin_ff) : '0;
      rsp.word_count    = COUNT_OUT_W'(words_ff);
      rsp.max_count     = COUNT_OUT_W'(largest_ff);
      rsp.max_length    = LENGTH_OUT_W'(longest_ff);
      rsp.overflow_seen = ovf_ff;
   end

   // Sequencer for clearing, read-modify-write and reporting.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      clr_addr_in = clr_addr_ff;
      bin_in      = bin_ff;
      words_in    = words_ff;
      largest_in  = largest_ff;
      longest_in  = longest_ff;
      ovf_in      = ovf_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = len;
      wr_data     = bumped;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            if (clr_addr_ff == LB'(BINS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + LB'(1);
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.kind == KIND_CLEAR) begin
                  state_in    = ST_CLEAR;
                  clr_addr_in = '0;
                  words_in    = '0;
                  largest_in  = '0;
                  longest_in  = '0;
                  ovf_in      = 1'b0;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            bin_in = in_range ? rd_data : '0;
            if (cmd_ff.close_word) begin
               if (cmd_ff.close_long) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  if (bumped > largest_ff) begin
                     largest_in = bumped;
                  end
                  if (len > longest_ff) begin
                     longest_in = len;
                  end
               end
               if (words_ff != '1) begin
                  words_in = words_ff + CB'(1);
               end
            end
            if (cmd_ff.kind == KIND_EOS || cmd_ff.kind == KIND_READ) begin
               state_in = ST_REPORT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         words_ff    <= '0;
         largest_ff  <= '0;
         longest_ff  <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         words_ff    <= words_in;
         largest_ff  <= largest_in;
         longest_ff  <= longest_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      bin_ff <= bin_in;
   end

endmodule

`default_nettype wire

### rtl/word_length_histogram.sv
// A byte that extends a word only updates the run length in the front part. A word close
// goes through the command queue; the back part reads the store when idle and writes it
// back in its data state, then a report or bin read waits in the report state while the
// result queue is full. The back part takes a new command only once back in idle.
// Reset is synchronous; afterward a clearing pass zeroes the RAM while full stays high.
// A clear item runs the same pass. Depends on wlh_pkg, wlh_front, wlh_fifo and wlh_back.
`timescale 1ns / 1ps
`default_nettype none

module word_length_histogram #(
   parameter int BINS       = wlh_pkg::BINS_DEFAULT,
   parameter int COUNT_BITS = wlh_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire wlh_pkg::req_type req_item,
   output logic                  empty,
   input  wire logic             pop,
   output wlh_pkg::rsp_type      rsp_item
);

   import wlh_pkg::*;

   logic    accept;
   logic    front_push;
   cmd_type front_cmd;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type head_cmd;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type back_rsp;
   logic    clearing;

   // Items are held off while the queue is full or the store is being cleared.
   assign full   = cmd_full || clearing;
   assign accept = push && !full;

   wlh_front #(
      .BINS (BINS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_item),
      .cmd_push (front_push),
      .cmd      (front_cmd)
   );

   wlh_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (head_cmd),
      .empty (cmd_empty)
   );

   wlh_back #(
      .BINS       (BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp),
      .clearing  (clearing)
   );

   wlh_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (back_rsp),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_item),
      .empty (empty)
   );

endmodule

`default_nettype wire

### rtl/wlh_checker.sv
// Port-level checks for the word length histogram, bound to the top level.
// Depends on wlh_pkg and word_length_histogram.
`timescale 1ns / 1ps
`default_nettype none

module wlh_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             full,
   input wire logic             empty,
   input wire logic             pop,
   input wire wlh_pkg::rsp_type rsp_item
);

   // The store is swept right after reset, so items are held off.
   a_clear_after_reset: assert property (@(posedge clock) $fell(reset) |-> full)
      else $error("full not held during the clearing pass after reset");

   // Reset drops any waiting result.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   // A recorded length or a nonzero bin implies some word was counted.
   a_length_needs_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.max_length != '0) |-> rsp_item.word_count != '0)
      else $error("max_length set with zero word_count");

   a_count_needs_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.max_count != '0) |-> rsp_item.word_count != '0)
      else $error("max_count set with zero word_count");

   // A waiting result holds until it is taken.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result changed before it was taken");

endmodule

bind word_length_histogram wlh_checker u_checker (.*);

`default_nettype wire

### bench/word_length_histogram_tb.sv
// Self-checking testbench for word_length_histogram: directed and random byte streams,
// end-of-stream reports, bin reads and clears, checked against an in-bench histogram model.
// Depends on wlh_pkg and the word_length_histogram RTL.
`timescale 1ns / 1ps

module word_length_histogram_tb;
   import wlh_pkg::*;

   localparam int BIN_TOTAL = BINS_DEFAULT;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_item = '0;
   rsp_type rsp_item;

   // Items waiting to be sent, and reports the histogram model says are due.
   req_type pending_items[$];
   rsp_type expected_reports[$];

   // Histogram model state.
   logic [31:0] bin_counts [0:BIN_TOTAL-1];
   logic [10:0] run_len;
   logic [31:0] words_seen;
   logic [31:0] peak_count;
   logic [9:0]  longest_len;
   logic        too_long_seen;

   // Run statistics.
   int failures = 0;
   int items_accepted = 0;
   int reports_checked = 0;
   int words_closed = 0;
   int long_words = 0;

   // Handshake bookkeeping.
   bit item_taken = 0;
   int send_gap = 0;
   int recv_gap = 0;
   rsp_type got_report;
   rsp_type want_report;

   word_length_histogram uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_word_byte(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // A random letter or digit.
   function automatic logic [7:0] random_word_byte();
      int k;
      k = $urandom_range(0, 61);
      if (k < 10)
         return 8'(8'h30 + k);
      else if (k < 36)
         return 8'(8'h41 + k - 10);
      else
         return 8'(8'h61 + k - 36);
   endfunction

   // A random byte that separates words.
   function automatic logic [7:0] random_gap_byte();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (is_word_byte(c));
      return c;
   endfunction

   // The fields that an opcode does not use get random content.
   task automatic add_item(input op_type op, input logic [7:0] ch, input logic [9:0] idx);
      req_type it;
      it.opcode    = op;
      it.char_byte = (op == OP_BYTE) ? ch : 8'($urandom_range(0, 255));
      it.bin_index = (op == OP_READ) ? idx : 10'($urandom_range(0, 1023));
      pending_items.push_back(it);
   endtask

   task automatic add_word(input int len);
      for (int i = 0; i < len; i++)
         add_item(OP_BYTE, random_word_byte(), '0);
   endtask

   task clear_histogram();
      for (int i = 0; i < BIN_TOTAL; i++)
         bin_counts[i] = '0;
      run_len       = '0;
      words_seen    = '0;
      peak_count    = '0;
      longest_len   = '0;
      too_long_seen = 1'b0;
   endtask

   // Ends the pending word, if any, and records its length.
   task close_pending_word();
      logic [31:0] v;
      if (run_len != 0) begin
         if (run_len < BIN_TOTAL) begin
            v = bin_counts[run_len[9:0]];
            if (v != '1)
               v = v + 1;
            bin_counts[run_len[9:0]] = v;
            if (v > peak_count)
               peak_count = v;
            if (run_len > longest_len)
               longest_len = run_len[9:0];
         end else begin
            too_long_seen = 1'b1;
            long_words++;
         end
         if (words_seen != '1)
            words_seen = words_seen + 1;
         words_closed++;
         run_len = '0;
      end
   endtask

   task queue_report(input logic [31:0] bin);
      rsp_type rep;
      rep.bin_count     = bin;
      rep.word_count    = words_seen;
      rep.max_count     = peak_count;
      rep.max_length    = longest_len;
      rep.overflow_seen = too_long_seen;
      expected_reports.push_back(rep);
   endtask

   // Advances the histogram model by one accepted item.
   task step_histogram(input req_type it);
      case (op_type'(it.opcode))
         OP_BYTE: begin
            if (is_word_byte(it.char_byte)) begin
               if (run_len < BIN_TOTAL)
                  run_len = run_len + 11'd1;
            end else begin
               close_pending_word();
            end
         end
         OP_EOS: begin
            close_pending_word();
            queue_report('0);
         end
         OP_READ: begin
            queue_report((it.bin_index < BIN_TOTAL) ? bin_counts[it.bin_index] : '0);
         end
         default: begin
            clear_histogram();
         end
      endcase
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // Driver: offers the next pending item, holding it until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!(push && !item_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (pending_items.size() >= 150 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 7) - 1;
            push <= 1'b0;
         end else if (pending_items.size() != 0) begin
            push     <= 1'b1;
            req_item <= pending_items[0];
         end else begin
            push <= 1'b0;
         end
      end
      item_taken = 0;
   end

   // Input side: an item is taken at a rising edge with push high and full low.
   always @(posedge clock) begin
      if (!reset && push && !full) begin
         step_histogram(req_item);
         void'(pending_items.pop_front());
         item_taken = 1;
         items_accepted++;
      end
   end

   // Result side: pop stalls in random bursts until the last part of the run.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pending_items.size() < 150) begin
         pop <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         pop <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(1, 7) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Monitor: each report taken is compared with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         got_report = rsp_item;
         if (expected_reports.size() == 0) begin
            $error("report with no expected report waiting");
            failures++;
         end else begin
            want_report = expected_reports.pop_front();
            check_field("bin_count", want_report.bin_count, got_report.bin_count);
            check_field("word_count", want_report.word_count, got_report.word_count);
            check_field("max_count", want_report.max_count, got_report.max_count);
            check_field("max_length", 32'(want_report.max_length),
                        32'(got_report.max_length));
            check_field("overflow_seen", 32'(want_report.overflow_seen),
                        32'(got_report.overflow_seen));
            reports_checked++;
         end
      end
   end

   initial begin
      int stop_at;
      int pick;
      clear_histogram();

      // Empty histogram, then every class boundary of the byte ranges.
      add_item(OP_READ, '0, 10'd0);
      add_item(OP_READ, '0, 10'd1023);
      add_item(OP_EOS, '0, '0);
      add_item(OP_BYTE, 8'h2F, '0);
      add_item(OP_BYTE, 8'h30, '0);
      add_item(OP_BYTE, 8'h39, '0);
      add_item(OP_BYTE, 8'h41, '0);
      add_item(OP_BYTE, 8'h5A, '0);
      add_item(OP_BYTE, 8'h61, '0);
      add_item(OP_BYTE, 8'h7A, '0);
      add_item(OP_BYTE, 8'h3A, '0);
      add_item(OP_BYTE, 8'h40, '0);
      add_item(OP_BYTE, 8'h5B, '0);
      add_item(OP_BYTE, 8'h60, '0);
      add_item(OP_BYTE, 8'h7B, '0);
      add_item(OP_BYTE, 8'hFF, '0);
      add_item(OP_BYTE, 8'h00, '0);
      // End of stream flushes a pending word.
      add_item(OP_BYTE, 8'h78, '0);
      add_item(OP_EOS, '0, '0);
      add_item(OP_READ, '0, 10'd1);
      add_item(OP_READ, '0, 10'd6);
      add_item(OP_EOS, '0, '0);
      // A clear drops a pending word along with everything else.
      add_item(OP_BYTE, 8'h71, '0);
      add_item(OP_BYTE, 8'h51, '0);
      add_item(OP_CLEAR, '0, '0);
      add_item(OP_READ, '0, 10'd2);
      add_item(OP_EOS, '0, '0);

      // A word too long to record, past where the run length saturates,
      // flushed by an end of stream; then a short word and a clear.
      add_word(BIN_TOTAL + 6);
      add_item(OP_EOS, '0, '0);
      add_item(OP_READ, '0, 10'd1023);
      add_word(1);
      add_item(OP_BYTE, 8'h20, '0);
      add_item(OP_READ, '0, 10'd1);
      add_item(OP_CLEAR, '0, '0);
      add_item(OP_EOS, '0, '0);

      // Random part: mostly words of random text between separators, plus
      // stray bytes, reports, bin reads and now and then a clear.
      stop_at = pending_items.size() + 300;
      while (pending_items.size() < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 58) begin
            add_word(($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 8));
            repeat ($urandom_range(1, 2))
               add_item(OP_BYTE, random_gap_byte(), '0);
         end else if (pick < 68) begin
            add_item(OP_BYTE, 8'($urandom_range(0, 255)), '0);
         end else if (pick < 80) begin
            add_item(OP_EOS, '0, '0);
         end else if (pick < 98) begin
            add_item(OP_READ, '0, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                               : 10'($urandom_range(0, 12)));
         end else if (pick == 98) begin
            add_word($urandom_range(1, 6));
            add_item(OP_EOS, '0, '0);
         end else begin
            add_item(OP_CLEAR, '0, '0);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to be taken and every report to arrive.
      while (pending_items.size() != 0)
         @(posedge clock);
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Sent %0d items (%0d words, %0d too long to record); checked %0d reports.",
               items_accepted, words_closed, long_words, reports_checked);
      if (failures == 0 && expected_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Give up if the run hangs.
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
